[sv/afp_pkg.sv]
// afp_pkg: shared types, character constants, error codes and helper functions
// for the ascii frame parser with crc-8 check; no dependencies
package afp_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  error_code;
        logic [7:0]  sequence_res;
        logic [7:0]  mode;
        logic [7:0]  status;
        logic [7:0]  target;
        logic [8:0]  x_pos;
        logic [7:0]  y_pos;
        logic [15:0] metric;
        logic [9:0]  confidence;
        logic [31:0] timestamp;
    } out_item_t;

    // last three characters of the line, held back from the data path
    typedef struct packed {
        logic       full;
        logic [7:0] head;
        logic [7:0] mid;
        logic [7:0] back;
    } tail_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_CHAR = 2'd1,
        FAULT_OVF  = 2'd2
    } fault_t;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    localparam logic [4:0] ERR_OK         = 5'd0;
    localparam logic [4:0] ERR_SHORT      = 5'd1;
    localparam logic [4:0] ERR_NO_STAR    = 5'd2;
    localparam logic [4:0] ERR_FORMAT     = 5'd3;
    localparam logic [4:0] ERR_MISMATCH   = 5'd4;
    localparam logic [4:0] ERR_PREFIX     = 5'd5;
    localparam logic [4:0] ERR_COUNT      = 5'd6;
    localparam logic [4:0] ERR_EMPTY      = 5'd7;
    localparam logic [4:0] ERR_NONDIGIT   = 5'd8;
    localparam logic [4:0] ERR_OVERFLOW   = 5'd9;
    localparam logic [4:0] ERR_RANGE_BASE = 5'd9;

    localparam logic [3:0] FIELD_LAST = 4'd8;
    localparam logic [3:0] FIELD_OVER = 4'd9;
    localparam logic [1:0] PREFIX_LEN = 2'd3;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch inside {[CH_ZERO:CH_NINE]}) begin
            r = {1'b1, ch[3:0]};
        end else if (ch inside {[CH_UC_A:CH_UC_F]}) begin
            r = {1'b1, 4'(ch - CH_UC_A + 8'd10)};
        end else if (ch inside {[CH_LC_A:CH_LC_F]}) begin
            r = {1'b1, 4'(ch - CH_LC_A + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0: r = CH_V;
            2'd1: r = CH_TWO;
            default: r = CH_COMMA;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] range_limit(input logic [2:0] f);
        logic [15:0] r;
        case (f)
            3'd4: r = 16'd319;
            3'd5: r = 16'd239;
            3'd6: r = 16'd65535;
            3'd7: r = 16'd1000;
            default: r = 16'd255;
        endcase
        return r;
    endfunction

endpackage

[sv/afp_tail_window.sv]
// afp_tail_window: three-character delay line that holds back the checksum tail
// depends on afp_pkg
module afp_tail_window
    import afp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  in_item_t   item,
    output tail_t      tail
);

    logic [7:0] tw_reg [3];
    logic [1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            tw_reg[0] <= tw_reg[1];
            tw_reg[1] <= tw_reg[2];
            tw_reg[2] <= item.char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else if (advance) begin
            if (item.last) begin
                fill_reg <= 2'd0;
            end else if (fill_reg != 2'd3) begin
                fill_reg <= fill_reg + 2'd1;
            end
        end
    end

    assign tail.full = (fill_reg == 2'd3);
    assign tail.head = tw_reg[0];
    assign tail.mid  = tw_reg[1];
    assign tail.back = tw_reg[2];

endmodule

[sv/afp_line_checker.sv]
// afp_line_checker: crc-8, prefix check, field parser and end-of-line verdict
// depends on afp_pkg
module afp_line_checker
    import afp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  in_item_t   item,
    input  tail_t      tail,
    output out_item_t  result
);

    logic        take;
    logic        line_end;
    logic [7:0]  d;

    logic [7:0]  crc_reg, crc_next;
    logic [1:0]  dpos_reg, dpos_next;
    logic        prefix_bad_reg, prefix_bad_next;
    logic        star_reg, star_next;
    logic [3:0]  fidx_reg, fidx_next;
    logic [31:0] acc_reg, acc_next;
    logic        has_digit_reg, has_digit_next;
    fault_t      fault_reg, fault_next;
    logic [3:0]  ffe_reg, ffe_next;
    logic [3:0]  fre_reg, fre_next;

    logic [7:0]  byte_reg [4];
    logic [8:0]  coord_reg [2];
    logic [15:0] metric_reg;
    logic [9:0]  conf_reg;
    logic        store_en;

    logic [35:0] acc_prod;
    logic        is_digit;
    logic [4:0]  hex_hi;
    logic [4:0]  hex_lo;
    logic [3:0]  ffe_final;
    logic [4:0]  code;

    assign take     = advance && tail.full;
    assign line_end = advance && item.last;
    assign d        = tail.head;

    assign is_digit = (d inside {[CH_ZERO:CH_NINE]});
    // acc * 10 + digit as two shifted copies and the digit
    assign acc_prod = 36'({acc_reg, 3'b000}) + 36'({acc_reg, 1'b0}) + 36'(d[3:0]);

    always_comb begin
        crc_next        = crc_reg;
        dpos_next       = dpos_reg;
        prefix_bad_next = prefix_bad_reg;
        star_next       = star_reg;
        fidx_next       = fidx_reg;
        acc_next        = acc_reg;
        has_digit_next  = has_digit_reg;
        fault_next      = fault_reg;
        ffe_next        = ffe_reg;
        fre_next        = fre_reg;
        store_en        = 1'b0;
        if (take) begin
            crc_next = crc8_step(crc_reg, d);
            if (d == CH_STAR) begin
                star_next = 1'b1;
            end
            if (dpos_reg != PREFIX_LEN) begin
                if (d != prefix_char(dpos_reg)) begin
                    prefix_bad_next = 1'b1;
                end
                dpos_next = dpos_reg + 2'd1;
            end else if (d == CH_COMMA) begin
                if (fidx_reg < FIELD_LAST) begin
                    if (ffe_reg == 4'd0) begin
                        if (!has_digit_reg) begin
                            ffe_next = 4'(ERR_EMPTY);
                        end else if (fault_reg == FAULT_CHAR) begin
                            ffe_next = 4'(ERR_NONDIGIT);
                        end else if (fault_reg == FAULT_OVF) begin
                            ffe_next = 4'(ERR_OVERFLOW);
                        end else begin
                            store_en = 1'b1;
                            if (fre_reg == 4'd0 &&
                                acc_reg > 32'(range_limit(fidx_reg[2:0]))) begin
                                fre_next = fidx_reg + 4'd1;
                            end
                        end
                    end
                    fidx_next = fidx_reg + 4'd1;
                end else if (fidx_reg == FIELD_LAST) begin
                    // a tenth field
                    if (ffe_reg == 4'd0) begin
                        ffe_next = 4'(ERR_COUNT);
                    end
                    fidx_next = FIELD_OVER;
                end
                acc_next       = 32'd0;
                has_digit_next = 1'b0;
                fault_next     = FAULT_NONE;
            end else if (fidx_reg <= FIELD_LAST) begin
                has_digit_next = 1'b1;
                if (fault_reg == FAULT_NONE) begin
                    if (is_digit) begin
                        if (acc_prod[35:32] != 4'd0) begin
                            fault_next = FAULT_OVF;
                        end else begin
                            acc_next = acc_prod[31:0];
                        end
                    end else begin
                        fault_next = FAULT_CHAR;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || line_end) begin
            crc_reg        <= 8'd0;
            dpos_reg       <= 2'd0;
            prefix_bad_reg <= 1'b0;
            star_reg       <= 1'b0;
            fidx_reg       <= 4'd0;
            acc_reg        <= 32'd0;
            has_digit_reg  <= 1'b0;
            fault_reg      <= FAULT_NONE;
            ffe_reg        <= 4'd0;
            fre_reg        <= 4'd0;
        end else if (take) begin
            crc_reg        <= crc_next;
            dpos_reg       <= dpos_next;
            prefix_bad_reg <= prefix_bad_next;
            star_reg       <= star_next;
            fidx_reg       <= fidx_next;
            acc_reg        <= acc_next;
            has_digit_reg  <= has_digit_next;
            fault_reg      <= fault_next;
            ffe_reg        <= ffe_next;
            fre_reg        <= fre_next;
        end
    end

    // decoded values of the first eight fields; only read when all of them were stored
    always_ff @(posedge aclk) begin
        if (store_en) begin
            case (fidx_reg[2:0])
                3'd0: byte_reg[0]  <= acc_reg[7:0];
                3'd1: byte_reg[1]  <= acc_reg[7:0];
                3'd2: byte_reg[2]  <= acc_reg[7:0];
                3'd3: byte_reg[3]  <= acc_reg[7:0];
                3'd4: coord_reg[0] <= acc_reg[8:0];
                3'd5: coord_reg[1] <= acc_reg[8:0];
                3'd6: metric_reg   <= acc_reg[15:0];
                default: conf_reg  <= acc_reg[9:0];
            endcase
        end
    end

    assign hex_hi = hex_val(tail.back);
    assign hex_lo = hex_val(item.char_in);

    // end-of-line verdict, taken on the state after the last data character
    always_comb begin
        ffe_final = ffe_next;
        if (fidx_next < FIELD_LAST) begin
            if (ffe_next == 4'd0) begin
                ffe_final = 4'(ERR_COUNT);
            end
        end else if (fidx_next == FIELD_LAST && ffe_next == 4'd0) begin
            if (!has_digit_next) begin
                ffe_final = 4'(ERR_EMPTY);
            end else if (fault_next == FAULT_CHAR) begin
                ffe_final = 4'(ERR_NONDIGIT);
            end else if (fault_next == FAULT_OVF) begin
                ffe_final = 4'(ERR_OVERFLOW);
            end
        end

        if (!tail.full || dpos_next != PREFIX_LEN) begin
            code = ERR_SHORT;
        end else if (tail.mid != CH_STAR) begin
            code = ERR_NO_STAR;
        end else if (star_next || !hex_hi[4] || !hex_lo[4]) begin
            code = ERR_FORMAT;
        end else if ({hex_hi[3:0], hex_lo[3:0]} != crc_next) begin
            code = ERR_MISMATCH;
        end else if (prefix_bad_next) begin
            code = ERR_PREFIX;
        end else if (ffe_final != 4'd0) begin
            code = 5'(ffe_final);
        end else if (fre_next != 4'd0) begin
            code = 5'(fre_next) + ERR_RANGE_BASE;
        end else begin
            code = ERR_OK;
        end
    end

    always_comb begin
        result            = '0;
        result.error_code = code;
        if (code == ERR_OK) begin
            result.sequence_res = byte_reg[0];
            result.mode         = byte_reg[1];
            result.status       = byte_reg[2];
            result.target       = byte_reg[3];
            result.x_pos        = coord_reg[0];
            result.y_pos        = coord_reg[1][7:0];
            result.metric       = metric_reg;
            result.confidence   = conf_reg;
            result.timestamp    = acc_next;
        end
    end

endmodule

[sv/ascii_frame_parser_crc8_unit.sv]
// ascii_frame_parser_crc8_unit: one character per transaction in, one result per line out
// m_valid is set as the last character moves from the input register to the result register
// throughput: one character per cycle; a line end waits while the result register is still full
// reset: aresetn synchronous active low clears all handshake and parser state
// depends on afp_pkg, afp_tail_window, afp_line_checker
module ascii_frame_parser_crc8_unit
    import afp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      advance;
    tail_t     tail;
    out_item_t result;

    // a line end needs a free result slot, other characters always move on
    assign advance = in_valid_reg && (!in_item_reg.last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    afp_tail_window u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .tail    (tail)
    );

    afp_line_checker u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .tail    (tail),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[verif/testbench.sv]
// testbench for ascii_frame_parser_crc8_unit: sends ascii lines one character per transaction
// and checks every line result against a line model kept in the bench
// depends on afp_pkg and the unit's rtl
`timescale 1ns / 1ps

import afp_pkg::*;

localparam int TAIL_DEPTH = 3;
localparam int NUM_FIELDS = 9;

function automatic longint unsigned field_max(input int f);
    case (f)
        0, 1, 2, 3: return 255;
        4: return 319;
        5: return 239;
        6: return 65535;
        7: return 1000;
        default: return 64'hFFFF_FFFF;
    endcase
endfunction

function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    r = crc ^ d;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
endfunction

function automatic int hex_digit(input logic [7:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return ch - CH_ZERO;
    if (ch >= CH_UC_A && ch <= CH_UC_F) return ch - CH_UC_A + 10;
    if (ch >= CH_LC_A && ch <= CH_LC_F) return ch - CH_LC_A + 10;
    return -1;
endfunction

function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return CH_ZERO + n;
    return (lower ? CH_LC_A : CH_UC_A) + n - 4'd10;
endfunction

class frame_scoreboard;
    logic [7:0]  tail_q [TAIL_DEPTH];
    logic [1:0]  tail_cnt;
    logic [7:0]  crc_acc;
    logic [1:0]  prefix_pos;
    logic        prefix_wrong;
    logic        star_early;
    logic [3:0]  field_no;
    logic [31:0] value;
    logic        has_digit;
    fault_t      fault;
    logic [4:0]  parse_err;
    logic [3:0]  range_field;
    out_item_t   decoded;
    out_item_t   pending_frames [$];
    int unsigned mismatches;
    int unsigned frames_checked;
    int unsigned code_hits [32];

    function new();
        mismatches = 0;
        frames_checked = 0;
        foreach (code_hits[i]) code_hits[i] = 0;
        clear_line();
    endfunction

    function void open_field();
        value = '0;
        has_digit = 1'b0;
        fault = FAULT_NONE;
    endfunction

    function void clear_line();
        foreach (tail_q[i]) tail_q[i] = '0;
        tail_cnt = '0;
        crc_acc = '0;
        prefix_pos = '0;
        prefix_wrong = 1'b0;
        star_early = 1'b0;
        field_no = '0;
        open_field();
        parse_err = ERR_OK;
        range_field = '0;
        decoded = '0;
    endfunction

    // first count or parse error wins; range errors are only remembered
    function void close_field();
        if (parse_err != ERR_OK || field_no > FIELD_LAST) return;
        if (!has_digit) begin
            parse_err = ERR_EMPTY;
        end else if (fault == FAULT_CHAR) begin
            parse_err = ERR_NONDIGIT;
        end else if (fault == FAULT_OVF) begin
            parse_err = ERR_OVERFLOW;
        end else begin
            if (field_no < FIELD_LAST && range_field == 0 && value > field_max(int'(field_no)))
                range_field = field_no + 4'd1;
            case (field_no)
                4'd0: decoded.sequence_res = value[7:0];
                4'd1: decoded.mode = value[7:0];
                4'd2: decoded.status = value[7:0];
                4'd3: decoded.target = value[7:0];
                4'd4: decoded.x_pos = value[8:0];
                4'd5: decoded.y_pos = value[7:0];
                4'd6: decoded.metric = value[15:0];
                4'd7: decoded.confidence = value[9:0];
                default: decoded.timestamp = value;
            endcase
        end
    endfunction

    function void take_char(input logic [7:0] d);
        logic [63:0] grown;
        crc_acc = crc8_next(crc_acc, d);
        if (d == CH_STAR) star_early = 1'b1;
        if (prefix_pos < PREFIX_LEN) begin
            if (d != ((prefix_pos == 0) ? CH_V : (prefix_pos == 1) ? CH_TWO : CH_COMMA))
                prefix_wrong = 1'b1;
            prefix_pos++;
            return;
        end
        if (d == CH_COMMA) begin
            if (field_no < FIELD_LAST) begin
                close_field();
                field_no++;
            end else if (field_no == FIELD_LAST) begin
                if (parse_err == ERR_OK) parse_err = ERR_COUNT;
                field_no = FIELD_OVER;
            end
            open_field();
            return;
        end
        if (field_no > FIELD_LAST) return;
        has_digit = 1'b1;
        if (fault != FAULT_NONE) return;
        if (d >= CH_ZERO && d <= CH_NINE) begin
            grown = {32'd0, value} * 64'd10 + {56'd0, 8'(d - CH_ZERO)};
            if (grown > 64'hFFFF_FFFF) fault = FAULT_OVF;
            else value = grown[31:0];
        end else begin
            fault = FAULT_CHAR;
        end
    endfunction

    function void note_char(input in_item_t it);
        logic [4:0] code;
        int         hi;
        int         lo;
        out_item_t  want;
        if (!it.last) begin
            // the last three characters never reach the data path
            if (tail_cnt == TAIL_DEPTH) begin
                take_char(tail_q[0]);
                tail_q[0] = tail_q[1];
                tail_q[1] = tail_q[2];
                tail_q[2] = it.char_in;
            end else begin
                tail_q[tail_cnt] = it.char_in;
                tail_cnt++;
            end
            return;
        end
        code = ERR_OK;
        if (tail_cnt < TAIL_DEPTH) begin
            code = ERR_SHORT;
        end else begin
            take_char(tail_q[0]);
            hi = hex_digit(tail_q[2]);
            lo = hex_digit(it.char_in);
            if (prefix_pos < PREFIX_LEN) code = ERR_SHORT;
            else if (tail_q[1] != CH_STAR) code = ERR_NO_STAR;
            else if (star_early || hi < 0 || lo < 0) code = ERR_FORMAT;
            else if (8'(hi * 16 + lo) != crc_acc) code = ERR_MISMATCH;
            else if (prefix_wrong) code = ERR_PREFIX;
            else begin
                if (field_no < FIELD_LAST) begin
                    if (parse_err == ERR_OK) parse_err = ERR_COUNT;
                end else if (field_no == FIELD_LAST) begin
                    close_field();
                end
                if (parse_err != ERR_OK) code = parse_err;
                else if (range_field != 0) code = ERR_RANGE_BASE + 5'(range_field);
            end
        end
        want = '0;
        if (code == ERR_OK) want = decoded;
        want.error_code = code;
        pending_frames.push_back(want);
        clear_line();
    endfunction

    task report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("frame %0d %s: got %0h, expected %0h",
                                      frames_checked, name, got, want));
    endtask

    task check_frame(input out_item_t got);
        out_item_t want;
        if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("result with no line pending, code %0d", got.error_code));
            return;
        end
        want = pending_frames.pop_front();
        frames_checked++;
        code_hits[want.error_code]++;
        compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
        compare_field("sequence_res", 32'(got.sequence_res), 32'(want.sequence_res));
        compare_field("mode", 32'(got.mode), 32'(want.mode));
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("target", 32'(got.target), 32'(want.target));
        compare_field("x_pos", 32'(got.x_pos), 32'(want.x_pos));
        compare_field("y_pos", 32'(got.y_pos), 32'(want.y_pos));
        compare_field("metric", 32'(got.metric), 32'(want.metric));
        compare_field("confidence", 32'(got.confidence), 32'(want.confidence));
        compare_field("timestamp", got.timestamp, want.timestamp);
    endtask

    function int unsigned codes_seen();
        int unsigned n;
        n = 0;
        foreach (code_hits[i]) if (code_hits[i] != 0) n++;
        return n;
    endfunction
endclass

module testbench;
    typedef enum int {
        LK_GOOD, LK_EXTREME, LK_RANGE, LK_EMPTY, LK_NONDIGIT, LK_OVERFLOW, LK_FEW, LK_MANY,
        LK_PREFIX, LK_CRC, LK_NOSTAR, LK_BADHEX, LK_STAR_DATA, LK_SHORT, LK_NOISE
    } line_kind_t;

    localparam int NUM_KINDS = LK_NOISE + 1;
    localparam int NUM_PHASES = 5;
    localparam int PRESSURE_PHASE = 4;
    localparam int unsigned PH_SRC [NUM_PHASES] = '{0, 79, 0, 16, 0};
    localparam int unsigned PH_SINK [NUM_PHASES] = '{0, 0, 79, 16, 0};
    localparam int unsigned PHASE_CHARS = 210;
    localparam int unsigned PHASE_LINES = 4;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int unsigned     src_idle_pct = 0;
    int unsigned     sink_stall_pct = 0;
    logic            sink_hold = 1'b0;
    logic            pressure_go = 1'b0;
    int unsigned     chars_sent = 0;
    int unsigned     lines_sent = 0;
    logic [7:0]      line_buf [$];
    frame_scoreboard sb = new();

    ascii_frame_parser_crc8_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_field(input line_kind_t kind, input int f, input bit is_bad);
        longint unsigned lim;
        longint unsigned v;
        int unsigned     start;
        logic [7:0]      junk;
        string           digits;
        lim = field_max(f);
        if (kind == LK_EXTREME) begin
            v = ($urandom_range(3) == 0) ? 0 : lim;
        end else begin
            case ($urandom_range(9))
                0: v = 0;
                1: v = lim;
                2, 3, 4, 5: v = $urandom_range(9);
                default: v = $urandom_range(32'(lim));
            endcase
        end
        if (is_bad && kind == LK_RANGE) v = lim + 1 + $urandom_range(lim > 300 ? 5000 : 20);
        digits = $sformatf("%0d", v);
        if ($urandom_range(7) == 0) digits = {"0", digits};
        if (is_bad && kind == LK_OVERFLOW) begin
            if ($urandom_range(3) == 0) begin
                digits = "4294967296";
            end else begin
                // ten or more digits led by 5..9 is always past 32 bits
                digits = $sformatf("%0d", $urandom_range(9, 5));
                repeat (9 + $urandom_range(2))
                    digits = {digits, $sformatf("%0d", $urandom_range(9))};
            end
        end
        if (is_bad && kind == LK_EMPTY) digits = "";
        start = line_buf.size();
        put_text(digits);
        if (is_bad && kind == LK_NONDIGIT) begin
            do begin
                junk = 8'($urandom());
            end while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_COMMA || junk == CH_STAR);
            line_buf.insert($urandom_range(line_buf.size(), start), junk);
        end
    endtask

    // appends '*' and two hex crc digits of the buffer; LK_CRC/LK_NOSTAR/LK_BADHEX spoil one
    task automatic seal_line(input line_kind_t kind);
        logic [7:0] crc;
        logic [7:0] ch;
        bit         lower;
        crc = '0;
        foreach (line_buf[i]) crc = crc8_next(crc, line_buf[i]);
        if (kind == LK_CRC) crc ^= 8'($urandom_range(255, 1));
        ch = CH_STAR;
        if (kind == LK_NOSTAR) begin
            do begin
                ch = 8'($urandom());
            end while (ch == CH_STAR);
        end
        line_buf.push_back(ch);
        lower = $urandom_range(1);
        line_buf.push_back(hex_char(crc[7:4], lower));
        line_buf.push_back(hex_char(crc[3:0], lower));
        if (kind == LK_BADHEX) begin
            do begin
                ch = 8'($urandom());
            end while (hex_digit(ch) >= 0);
            line_buf[line_buf.size() - 1 - $urandom_range(1)] = ch;
        end
    endtask

    task automatic build_line(input line_kind_t kind);
        int unsigned n_fields;
        int unsigned bad_f;
        int unsigned len;
        int unsigned pos;
        logic [7:0]  ch;
        line_buf.delete();
        if (kind == LK_SHORT || kind == LK_NOISE) begin
            len = (kind == LK_SHORT) ? $urandom_range(5, 1) : $urandom_range(40, 1);
            repeat (len) line_buf.push_back(8'($urandom()));
        end else begin
            n_fields = NUM_FIELDS;
            if (kind == LK_FEW) n_fields = $urandom_range(NUM_FIELDS - 1, 1);
            if (kind == LK_MANY) n_fields = $urandom_range(NUM_FIELDS + 3, NUM_FIELDS + 1);
            bad_f = (kind == LK_RANGE) ? $urandom_range(7) : $urandom_range(8);
            put_text("V2,");
            for (int f = 0; f < n_fields; f++) begin
                if (f != 0) line_buf.push_back(CH_COMMA);
                put_field(kind, (f > 8) ? 8 : f, f == bad_f);
            end
            if (kind == LK_PREFIX) begin
                pos = $urandom_range(2);
                do begin
                    ch = 8'($urandom());
                end while (ch == line_buf[pos]);
                line_buf[pos] = ch;
            end
            if (kind == LK_STAR_DATA) line_buf.insert($urandom_range(line_buf.size() - 1), CH_STAR);
            seal_line(kind);
        end
    endtask

    task automatic put_char(input in_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(it);
        chars_sent++;
    endtask

    task automatic send_line();
        in_item_t it;
        foreach (line_buf[i]) begin
            it.char_in = line_buf[i];
            it.last = (i == line_buf.size() - 1);
            put_char(it);
        end
        lines_sent++;
    endtask

    // result side: check every transaction, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_frame(m_data);
        m_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // long output hold so the unit backs up onto its input
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", sb.pending_frames.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned phase_start;
        int unsigned phase_lines;
        int unsigned kind_no;
        line_kind_t  kind;
        kind_no = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // line of one character, line too short to fill the prefix, bare prefix line
        line_buf = '{8'hFF};
        send_line();
        line_buf = '{8'h00, CH_V, CH_TWO, CH_COMMA, CH_STAR};
        send_line();
        line_buf = '{CH_V, CH_TWO, CH_COMMA};
        seal_line(LK_GOOD);
        send_line();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            src_idle_pct = PH_SRC[ph];
            sink_stall_pct = PH_SINK[ph];
            if (ph == PRESSURE_PHASE) pressure_go = 1'b1;
            phase_start = chars_sent;
            phase_lines = lines_sent;
            while (chars_sent - phase_start < PHASE_CHARS ||
                   lines_sent - phase_lines < PHASE_LINES) begin
                // one line of each kind first, then well-formed lines 45 percent of the time
                if (kind_no < NUM_KINDS) kind = line_kind_t'(kind_no);
                else if ($urandom_range(99) < 45)
                    kind = ($urandom_range(4) == 0) ? LK_EXTREME : LK_GOOD;
                else kind = line_kind_t'($urandom_range(int'(LK_NOISE), int'(LK_RANGE)));
                kind_no++;
                build_line(kind);
                send_line();
            end
        end
        s_valid <= 1'b0;

        while (sb.pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending_frames.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_frames.size()));

        $display("sent %0d characters in %0d lines across idle, stall and %0d-cycle hold phases",
                 chars_sent, lines_sent, HOLD_CYCLES);
        $display("checked %0d results covering %0d distinct error codes, %0d mismatches",
                 sb.frames_checked, sb.codes_seen(), sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
